FILE: sv/arenv_pkg.sv
// ----------------------------------------------------------------------------
// Attack/release envelope package
// Shared constants, types and state codes of the envelope generator.
// ----------------------------------------------------------------------------
package arenv_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int DIVIDEND_W = 56;
	localparam int DIVISOR_W = 42;
	localparam int LEVEL_W = 40;
	localparam int COUNT_W = 32;

	localparam logic [39:0] ONE_Q39 = 40'h80_0000_0000;
	localparam logic [40:0] ONE_Q40 = 41'h100_0000_0000;
	localparam logic [35:0] LOG2_1000_Q32 = 36'd42802717582;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [55:0] LIN_NUM = 56'h80_0000_0000_0000;
	localparam logic [3:0] K_LAST = 4'd14;
	localparam logic [23:0] N_LIMIT = 24'd40;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		REG_SAMPLE_RATE = 2'd0,
		REG_ATTACK_SHAPE = 2'd1,
		REG_RELEASE_SHAPE = 2'd2
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_SEL, S_LDIV, S_XDIV, S_TLO, S_THI, S_TDIV,
		S_COEF, S_EM1, S_EM2, S_EM3, S_DONE
	} state_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [COUNT_W-1:0] count;
		logic gate;
	} entry_t;

endpackage

FILE: sv/arenv_div.sv
// ----------------------------------------------------------------------------
// Envelope divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arenv_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [arenv_pkg::DIVIDEND_W-1:0] dividend,
	input logic [arenv_pkg::DIVISOR_W-1:0] divisor,
	output logic done,
	output logic [arenv_pkg::DIVIDEND_W-1:0] quotient
);
	import arenv_pkg::*;

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0] den_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W+1:0] diff;
	logic ge;

	assign trial = {rem_q, num_q[DIVIDEND_W-1]};
	assign diff = {1'b0, trial} - {2'b00, den_q};
	assign ge = !diff[DIVISOR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIVIDEND_W-2:0], 1'b0};
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/arenv_mem.sv
// ----------------------------------------------------------------------------
// Envelope state memory
// Per-channel level, segment count and gate, with a registered read.
// ----------------------------------------------------------------------------
module arenv_mem #(
	parameter int CHANNELS = arenv_pkg::CHANNELS_DEF,
	parameter int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input arenv_pkg::entry_t wr_data,
	output arenv_pkg::entry_t rd_data
);
	import arenv_pkg::*;

	entry_t mem_q [CHANNELS];
	entry_t rd_q;
	logic [CHANNELS-1:0] valid_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

FILE: sv/attack_release_envelope.sv
// A result is loaded once the result register is free. A linear segment takes a
// divide; an exponential one a divide, the series terms (skipped if the
// coefficient underflows) and scaling; a zero time or out-of-range channel none.
// One request at a time, the next accepted once idle again after the result is loaded;
// the shared 56-step divider runs once per linear request, fifteen per full series.
// Reset restores the register defaults and marks every channel's state as zero.
// ----------------------------------------------------------------------------
// Attack/release envelope generator
// Multi-channel envelope with linear or exponential attack and release.
// ----------------------------------------------------------------------------
module attack_release_envelope #(
	parameter int CHANNELS = arenv_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [17:0] cfg_data,
	input logic item_valid,
	output logic item_ready,
	input logic [2:0] channel,
	input logic gate,
	input logic restart,
	input logic [23:0] attack_time,
	input logic [23:0] release_time,
	output logic result_valid,
	input logic result_ready,
	output logic [2:0] out_channel,
	output logic [23:0] level,
	output logic [31:0] elapsed_samples
);
	import arenv_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	state_t state_q, state_d;

	logic [17:0] sample_rate_q;
	logic attack_shape_q;
	logic release_shape_q;

	logic [2:0] ch_q;
	logic [AW-1:0] addr_q;
	logic inrange_q;
	logic gate_q;
	logic restart_q;
	logic [23:0] at_q;
	logic [23:0] rt_q;
	logic shape_q;
	logic [39:0] lev_q;
	logic [31:0] cnt_q;
	logic [41:0] p_q;
	logic [39:0] coef_q;
	logic [31:0] r_q;
	logic [40:0] term_q;
	logic [41:0] sum_q;
	logic [3:0] k_q;
	logic [5:0] n_q;
	logic [63:0] plo_q;
	logic [59:0] pl_q;
	logic [59:0] ph_q;

	logic result_valid_q;
	logic [2:0] out_channel_q;
	logic [23:0] level_q;
	logic [31:0] elapsed_q;

	logic accept;
	logic in_range;
	logic load_out;
	logic div_start;
	logic [DIVIDEND_W-1:0] div_num;
	logic [DIVISOR_W-1:0] div_den;
	logic div_done;
	logic [DIVIDEND_W-1:0] div_quo;
	entry_t rd_entry;
	entry_t wr_entry;
	logic mem_we;

	logic [39:0] lev_rd;
	logic [23:0] tsel;
	logic [41:0] p_next;
	logic [41:0] acc;
	logic [39:0] st;
	logic [40:0] lin_sum;
	logic [39:0] opnd;
	logic [79:0] prod;
	logic [39:0] m;
	logic [63:0] rprod;

	assign in_range = 32'(channel) < CHANNELS;
	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= 18'd48000;
			attack_shape_q <= 1'b0;
			release_shape_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				REG_ATTACK_SHAPE: attack_shape_q <= cfg_data[0];
				REG_RELEASE_SHAPE: release_shape_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		item_ready = 1'b0;
		load_out = 1'b0;
		div_start = 1'b0;
		div_num = {15'b0, p_q[41:1]} + LIN_NUM;
		div_den = p_q;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = in_range ? S_READ : S_DONE;
				end
			end
			S_READ: state_d = S_SEL;
			S_SEL: begin
				if (p_q == '0) begin
					state_d = S_DONE;
				end else begin
					div_start = 1'b1;
					if (!shape_q) begin
						state_d = S_LDIV;
					end else begin
						div_num = {4'b0, LOG2_1000_Q32, 16'b0};
						state_d = S_XDIV;
					end
				end
			end
			S_LDIV: if (div_done) begin
				state_d = S_DONE;
			end
			S_XDIV: if (div_done) begin
				state_d = (div_quo[55:32] >= N_LIMIT) ? S_EM1 : S_TLO;
			end
			S_TLO: state_d = S_THI;
			S_THI: begin
				div_start = 1'b1;
				div_num = {14'b0, acc};
				div_den = {38'b0, k_q};
				state_d = S_TDIV;
			end
			S_TDIV: if (div_done) begin
				state_d = (k_q == K_LAST) ? S_COEF : S_TLO;
			end
			S_COEF: state_d = S_EM1;
			S_EM1: state_d = S_EM2;
			S_EM2: state_d = S_EM3;
			S_EM3: state_d = S_DONE;
			S_DONE: begin
				if (!result_valid_q || result_ready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign lev_rd = (rd_entry.level > ONE_Q39) ? ONE_Q39 : rd_entry.level;
	assign tsel = gate_q ? at_q : rt_q;
	assign p_next = tsel * sample_rate_q;
	assign acc = term_q[40:32] * r_q + {10'b0, plo_q[63:32]};
	assign st = (div_quo > {16'b0, ONE_Q39}) ? ONE_Q39 : div_quo[39:0];
	assign lin_sum = {1'b0, lev_q} + {1'b0, st};
	assign opnd = gate_q ? (ONE_Q39 - lev_q) : lev_q;
	assign prod = {ph_q, 20'b0} + {20'b0, pl_q};
	assign m = prod[78:39];
	assign rprod = div_quo[31:0] * LN2_Q32;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				ch_q <= channel;
				addr_q <= AW'(channel);
				inrange_q <= in_range;
				gate_q <= gate;
				restart_q <= restart;
				at_q <= attack_time;
				rt_q <= release_time;
			end
			S_READ: begin
				cnt_q <= (restart_q || rd_entry.gate != gate_q) ? '0 : rd_entry.count;
				if (restart_q) begin
					lev_q <= gate_q ? '0 : ONE_Q39;
				end else begin
					lev_q <= lev_rd;
				end
				p_q <= p_next;
				shape_q <= gate_q ? attack_shape_q : release_shape_q;
			end
			S_SEL: if (p_q == '0) begin
				lev_q <= gate_q ? ONE_Q39 : '0;
			end
			S_LDIV: if (div_done) begin
				if (gate_q) begin
					lev_q <= (lin_sum > {1'b0, ONE_Q39}) ? ONE_Q39 : lin_sum[39:0];
				end else begin
					lev_q <= (lev_q > st) ? (lev_q - st) : '0;
				end
			end
			S_XDIV: if (div_done) begin
				coef_q <= '0;
				n_q <= div_quo[37:32];
				r_q <= rprod[63:32];
				term_q <= ONE_Q40;
				sum_q <= {1'b0, ONE_Q40};
				k_q <= 4'd1;
			end
			S_TLO: plo_q <= term_q[31:0] * r_q;
			S_TDIV: if (div_done) begin
				term_q <= div_quo[40:0];
				sum_q <= k_q[0] ? (sum_q - {1'b0, div_quo[40:0]})
					: (sum_q + {1'b0, div_quo[40:0]});
				k_q <= k_q + 4'd1;
			end
			S_COEF: coef_q <= 40'(sum_q >> ({1'b0, n_q} + 7'd1));
			S_EM1: pl_q <= coef_q * opnd[19:0];
			S_EM2: ph_q <= coef_q * opnd[39:20];
			S_EM3: lev_q <= gate_q ? (ONE_Q39 - m) : m;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_channel_q <= ch_q;
			level_q <= inrange_q ? lev_q[39:16] : '0;
			elapsed_q <= inrange_q ? cnt_q : '0;
		end
	end

	assign mem_we = load_out && inrange_q;
	assign wr_entry.level = lev_q;
	assign wr_entry.count = (cnt_q == COUNT_MAX) ? cnt_q : (cnt_q + 32'd1);
	assign wr_entry.gate = gate_q;

	arenv_mem #(
		.CHANNELS(CHANNELS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(AW'(channel)),
		.wr_en(mem_we),
		.wr_addr(addr_q),
		.wr_data(wr_entry),
		.rd_data(rd_entry)
	);

	arenv_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_num),
		.divisor(div_den),
		.done(div_done),
		.quotient(div_quo)
	);

	assign result_valid = result_valid_q;
	assign out_channel = out_channel_q;
	assign level = level_q;
	assign elapsed_samples = elapsed_q;

`ifndef SYNTHESIS
	a_write_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_DONE)
		else $error("State memory written outside the final step.");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> level <= 24'h80_0000)
		else $error("Level above unity.");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_LDIV || state_q == S_XDIV || state_q == S_TDIV)
		else $error("Divider finished while no request waits for it.");
	a_term_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TDIV |-> k_q >= 4'd1 && k_q <= K_LAST)
		else $error("Series term index out of range.");
	a_coef_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EM1 |-> coef_q <= ONE_Q39)
		else $error("Exponential coefficient above unity.");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Envelope generator testbench
// Drives channel requests and register writes into the attack/release envelope
// block, predicts each level and sample count in fixed point and checks every
// result in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
import arenv_pkg::*;

class envelope_scoreboard;
	typedef struct {
		logic [2:0] ch;
		logic [23:0] lev;
		logic [31:0] cnt;
	} env_result_t;

	logic [17:0] rate;
	logic atk_exp;
	logic rel_exp;
	logic [39:0] lev_mem [8];
	logic [31:0] cnt_mem [8];
	logic gate_mem [8];
	env_result_t pending_q [$];
	int errors;

	function new();
		rate = 18'd48000;
		atk_exp = 1'b0;
		rel_exp = 1'b0;
		errors = 0;
		for (int i = 0; i < 8; i++) begin
			lev_mem[i] = '0;
			cnt_mem[i] = '0;
			gate_mem[i] = 1'b0;
		end
	endfunction

	function void write_reg(reg_index_t idx, logic [17:0] val);
		case (idx)
			REG_SAMPLE_RATE: rate = val;
			REG_ATTACK_SHAPE: atk_exp = val[0];
			REG_RELEASE_SHAPE: rel_exp = val[0];
			default: ;
		endcase
	endfunction

	function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return 64'(prod >> s);
	endfunction

	function logic [63:0] ramp_step(logic [63:0] p);
		logic [63:0] st;
		st = ((64'd1 << 55) + (p >> 1)) / p;
		return (st > 64'(ONE_Q39)) ? 64'(ONE_Q39) : st;
	endfunction

	function logic [63:0] decay_coef(logic [63:0] p);
		logic [63:0] x, n, r, term, sum;
		x = (64'(LOG2_1000_Q32) << 16) / p;
		n = x >> 32;
		if (n >= 64'd40)
			return 64'd0;
		r = ({32'd0, x[31:0]} * 64'(LN2_Q32)) >> 32;
		term = 64'd1 << 40;
		sum = term;
		for (int k = 1; k <= 14; k++) begin
			term = mul_shift(term, r, 32) / k;
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum >> (n + 1);
	endfunction

	function void note_request(logic [2:0] ch, logic g, logic rs, logic [23:0] at,
			logic [23:0] rt);
		logic [63:0] lev, p, one;
		logic [31:0] cnt;
		env_result_t e;
		one = 64'(ONE_Q39);
		lev = 64'(lev_mem[ch]);
		if (lev > one)
			lev = one;
		cnt = cnt_mem[ch];
		if (rs || gate_mem[ch] != g)
			cnt = '0;
		if (g) begin
			if (rs)
				lev = 0;
			p = 64'(at) * 64'(rate);
			if (p == 0)
				lev = one;
			else if (!atk_exp) begin
				lev = lev + ramp_step(p);
				if (lev > one)
					lev = one;
			end else
				lev = one - mul_shift(decay_coef(p), one - lev, 39);
		end else begin
			if (rs)
				lev = one;
			p = 64'(rt) * 64'(rate);
			if (p == 0)
				lev = 0;
			else if (!rel_exp)
				lev = (lev > ramp_step(p)) ? lev - ramp_step(p) : 64'd0;
			else
				lev = mul_shift(lev, decay_coef(p), 39);
		end
		e.ch = ch;
		e.lev = lev[39:16];
		e.cnt = cnt;
		pending_q.insert(pending_q.size(), e);
		lev_mem[ch] = lev[39:0];
		cnt_mem[ch] = (cnt == COUNT_MAX) ? cnt : cnt + 32'd1;
		gate_mem[ch] = g;
	endfunction

	function void check_result(logic [2:0] ch, logic [23:0] lev, logic [31:0] cnt);
		env_result_t e;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected result ch=%0d level=%0d count=%0d", $time, ch, lev,
				cnt);
			errors++;
			return;
		end
		e = pending_q.pop_front();
		if (ch !== e.ch) begin
			$display("%0t: out_channel expected %0d actual %0d", $time, e.ch, ch);
			errors++;
		end
		if (lev !== e.lev) begin
			$display("%0t: level expected %0d actual %0d", $time, e.lev, lev);
			errors++;
		end
		if (cnt !== e.cnt) begin
			$display("%0t: elapsed_samples expected %0d actual %0d", $time, e.cnt, cnt);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 3000;
	localparam int CYCLE_LIMIT = 6000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [17:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [2:0] channel = '0;
	logic gate = 1'b0;
	logic restart = 1'b0;
	logic [23:0] attack_time = '0;
	logic [23:0] release_time = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [2:0] out_channel;
	logic [23:0] level;
	logic [31:0] elapsed_samples;

	envelope_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	logic last_gate_tb [8] = '{default: 1'b0};

	attack_release_envelope u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready),
		.channel(channel), .gate(gate), .restart(restart),
		.attack_time(attack_time), .release_time(release_time),
		.result_valid(result_valid), .result_ready(result_ready),
		.out_channel(out_channel), .level(level), .elapsed_samples(elapsed_samples)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		int n;
		n = 0;
		forever begin
			@(posedge clk);
			n++;
			if (n >= CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) begin
					@(posedge clk);
					if (result_valid && result_ready)
						sb.check_result(out_channel, level, elapsed_samples);
				end
			end
		end
	end

	task automatic send_request(logic [2:0] ch, logic g, logic rs, logic [23:0] at,
			logic [23:0] rt);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item_valid <= 1'b1;
		channel <= ch;
		gate <= g;
		restart <= rs;
		attack_time <= at;
		release_time <= rt;
		do @(posedge clk); while (!item_ready);
		sb.note_request(ch, g, rs, at, rt);
		last_gate_tb[ch] = g;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [17:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(reg_index_t'(idx), val);
		@(posedge clk);
	endtask

	function automatic logic [23:0] pick_time();
		case ($urandom_range(0, 7))
			0: return 24'd0;
			1, 2: return 24'($urandom());
			3: return 24'($urandom_range(1, 16));
			default: return 24'($urandom_range(1, 70000));
		endcase
	endfunction

	task automatic random_request();
		logic [2:0] ch;
		logic g;
		ch = 3'($urandom());
		g = ($urandom_range(0, 9) < 7) ? last_gate_tb[ch] : ~last_gate_tb[ch];
		send_request(ch, g, $urandom_range(0, 15) == 0, pick_time(), pick_time());
	endtask

	initial begin
		logic [17:0] rates [5];
		rates = '{18'd1000, 18'd192000, 18'd48000, 18'd262143, 18'd0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(3'd0, 1'b1, 1'b0, 24'd0, 24'd0);
		send_request(3'd0, 1'b1, 1'b0, 24'd100, 24'd0);
		send_request(3'd0, 1'b0, 1'b0, 24'd0, 24'd0);
		send_request(3'd1, 1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
		send_request(3'd1, 1'b1, 1'b0, 24'hFFFFFF, 24'hFFFFFF);
		send_request(3'd1, 1'b0, 1'b1, 24'hFFFFFF, 24'd1);
		send_request(3'd7, 1'b1, 1'b0, 24'd1, 24'd1);
		send_request(3'd7, 1'b0, 1'b0, 24'd1, 24'd1);
		send_request(3'd7, 1'b0, 1'b1, 24'd1, 24'd50);
		drain();
		write_reg(REG_ATTACK_SHAPE, 18'd1);
		write_reg(REG_RELEASE_SHAPE, 18'd1);
		write_reg(REG_UNUSED, 18'h3FFFF);
		send_request(3'd2, 1'b1, 1'b0, 24'd1, 24'd1);
		send_request(3'd2, 1'b1, 1'b0, 24'hFFFFFF, 24'd0);
		send_request(3'd2, 1'b1, 1'b1, 24'd65536, 24'd0);
		send_request(3'd2, 1'b0, 1'b0, 24'd0, 24'hFFFFFF);
		send_request(3'd3, 1'b0, 1'b1, 24'd0, 24'd6554);
		send_request(3'd3, 1'b0, 1'b0, 24'd0, 24'd0);
		send_request(3'd4, 1'b1, 1'b0, 24'd3, 24'd3);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_SAMPLE_RATE, (ph < 5) ? rates[ph] : 18'($urandom_range(1000, 192000)));
			write_reg(REG_ATTACK_SHAPE, 18'($urandom_range(0, 1)));
			write_reg(REG_RELEASE_SHAPE, 18'($urandom_range(0, 1)));
			if (ph == 9)
				quiet = 1'b1;
			for (int i = 0; i < 88; i++) begin
				if (ph == 3 && i == 10)
					hold_req = 1'b1;
				random_request();
			end
			if (ph == 5) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending_q.size() != 0)
					@(posedge clk);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
